// File: rtl/core/easing_curve_evaluator_defines.svh
// ----------------------------------------------------------------------------
// easing_curve_evaluator_defines
// assertion macros for the checker file of the easing curve evaluator
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_EVALUATOR_DEFINES_SVH
`define EASING_CURVE_EVALUATOR_DEFINES_SVH

// property checked only while out of reset
`define ECE_ASSERT_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("easing curve evaluator check failed");

// property checked on every edge, reset included
`define ECE_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("easing curve evaluator check failed");

`endif

// File: rtl/core/ece_pkg.sv
// ----------------------------------------------------------------------------
// ece_pkg
// constants and tables of the easing curve evaluator
// ----------------------------------------------------------------------------
package ece_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = FRAC_BITS + 2;
    localparam int OUT_W     = FRAC_BITS + 1;
    localparam int NS        = 25;

    localparam logic [OUT_W-1:0] ONE = OUT_W'(1) << FRAC_BITS;

    localparam logic [2:0] MODE_LINEAR = 3'd0;
    localparam logic [2:0] MODE_QUAD   = 3'd1;
    localparam logic [2:0] MODE_CUBIC  = 3'd2;
    localparam logic [2:0] MODE_QUART  = 3'd3;
    localparam logic [2:0] MODE_QUINT  = 3'd4;
    localparam logic [2:0] MODE_CIRC   = 3'd5;
    localparam logic [2:0] MODE_SINE   = 3'd6;
    // unused code, evaluated as linear
    localparam logic [2:0] MODE_SPARE  = 3'd7;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'd1 << 30;

    // horner divisors 2k(2k+1) for k = 7 down to 1, and floor(2^32 / divisor)
    localparam logic [31:0] SIN_DIV [0:6] = '{
        32'd210, 32'd156, 32'd110, 32'd72, 32'd42, 32'd20, 32'd6
    };
    localparam logic [31:0] SIN_RECIP [0:6] = '{
        32'(64'd4294967296 / 64'd210), 32'(64'd4294967296 / 64'd156),
        32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
        32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd20),
        32'(64'd4294967296 / 64'd6)
    };

endpackage

// File: rtl/core/easing_curve_evaluator.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// maps signed Q16 animation progress to an eased Q16 position
// ----------------------------------------------------------------------------
// usage:
//   input transaction: i_progress is taken at each rising edge with start
//   high; busy is always low, so a new transaction may come every cycle.
//   curve select: i_cfg_data is written to the mode register when i_cfg_we
//   is high; write it only while no transaction is in flight.
//   result: o_position is shown for one cycle with o_valid high, in input
//   order.
//   throughput: one transaction per cycle; the pipeline depth is set by the sine
//   path (angle, square, seven horner steps of three stages each, final
//   product and output register).
//   power and root curves finish earlier and ride along in the pipeline.
//   reset clears all valid bits and selects the linear curve.
//   the receiver cannot stall: every result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module easing_curve_evaluator
    import ece_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  i_progress,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_data,
    output logic                    o_valid,
    output logic [OUT_W-1:0]        o_position
);

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] root;
    } t_sq;

    function automatic t_sq sqrt_step(t_sq cur, logic [1:0] bits);
        t_sq         nxt;
        logic [17:0] acc;
        logic [17:0] trial;
        acc   = {cur.rem[15:0], bits};
        trial = {cur.root, 2'b01};
        if (acc >= trial) begin
            nxt.rem  = 17'(acc - trial);
            nxt.root = {cur.root[14:0], 1'b1};
        end else begin
            nxt.rem  = acc[16:0];
            nxt.root = {cur.root[14:0], 1'b0};
        end
        return nxt;
    endfunction

    logic [2:0]       r_curve_mode;
    logic [NS:1]      r_vld;
    logic [2:0]       r_mode [1:NS-1];
    logic             r_pin  [1:NS-1];
    logic [OUT_W-1:0] r_res  [1:NS];
    logic [15:0]      r_u    [1:3];
    logic [79:0]      r_pw   [1:4];
    logic [31:0]      r_n    [1:5];
    t_sq              r_sq   [1:5];
    logic [30:0]      r_a    [1:23];
    logic [31:0]      r_a2   [2:20];
    logic [30:0]      r_h    [2:23];
    logic [31:0]      r_sp   [3:22];
    logic [31:0]      r_q    [4:22];
    logic [31:0]      r_s;

    logic [15:0]      n_x;
    logic             n_pin;
    logic [OUT_W-1:0] n_res1;
    t_sq              n_sq   [2:5];
    logic [16:0]      n_v;
    logic [OUT_W-1:0] n_pw_res;
    logic [OUT_W-1:0] n_circ_res;
    logic [OUT_W-1:0] n_sin_res;
    logic [17:0]      n_sin_rnd;
    logic [30:0]      n_h    [0:6];
    logic [31:0]      n_rem  [0:6];
    logic [31:0]      n_t    [0:6];

    assign busy       = 1'b0;
    assign o_valid    = r_vld[NS];
    assign o_position = r_res[NS];

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode <= MODE_LINEAR;
        end else if (i_cfg_we) begin
            r_curve_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-1:1], start};
        end
    end

    // entry decode
    always_comb begin
        n_x    = i_progress[15:0];
        n_pin  = 1'b1;
        n_res1 = {1'b0, n_x};
        if (i_progress[IN_W-1] || (i_progress == '0)) begin
            n_res1 = '0;
        end else if (i_progress[FRAC_BITS]) begin
            n_res1 = ONE;
        end else if ((r_curve_mode != MODE_LINEAR) && (r_curve_mode <= MODE_SINE)) begin
            n_pin = 1'b0;
        end
    end

    always_comb begin
        n_sq[2] = r_sq[1];
        for (int i = 0; i < 4; i++) begin
            n_sq[2] = sqrt_step(n_sq[2], r_n[1][31-2*i -: 2]);
        end
        n_sq[3] = r_sq[2];
        for (int i = 0; i < 4; i++) begin
            n_sq[3] = sqrt_step(n_sq[3], r_n[2][23-2*i -: 2]);
        end
        n_sq[4] = r_sq[3];
        for (int i = 0; i < 4; i++) begin
            n_sq[4] = sqrt_step(n_sq[4], r_n[3][15-2*i -: 2]);
        end
        n_sq[5] = r_sq[4];
        for (int i = 0; i < 4; i++) begin
            n_sq[5] = sqrt_step(n_sq[5], r_n[4][7-2*i -: 2]);
        end
        n_circ_res = (r_sq[5].rem > {1'b0, r_sq[5].root}) ?
                     OUT_W'(r_sq[5].root) + OUT_W'(1) : OUT_W'(r_sq[5].root);
    end

    // power curve rounding
    always_comb begin
        case (r_mode[4])
            MODE_QUAD:  n_v = 17'((33'(r_pw[4][31:0]) + (33'd1 << 15)) >> 16);
            MODE_CUBIC: n_v = 17'((49'(r_pw[4][47:0]) + (49'd1 << 31)) >> 32);
            MODE_QUART: n_v = 17'((65'(r_pw[4][63:0]) + (65'd1 << 47)) >> 48);
            MODE_QUINT: n_v = 17'((81'(r_pw[4]) + (81'd1 << 63)) >> 64);
            default:    n_v = '0;
        endcase
        n_pw_res = (n_v >= ONE) ? '0 : ONE - n_v;
    end

    // horner quotient correction and sine output rounding
    always_comb begin
        for (int j = 0; j < 7; j++) begin
            n_rem[j] = r_sp[4+3*j] - 32'(r_q[4+3*j] * SIN_DIV[j]);
            n_t[j]   = r_q[4+3*j] + 32'(n_rem[j] >= SIN_DIV[j]);
            n_h[j]   = (n_t[j] >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - n_t[j]);
        end
        n_sin_rnd = 18'((33'(r_s) + 33'd8192) >> 14);
        n_sin_res = (n_sin_rnd >= 18'(ONE)) ? ONE : OUT_W'(n_sin_rnd);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 2; k <= NS - 1; k++) begin
            r_mode[k] <= r_mode[k-1];
            r_pin[k]  <= r_pin[k-1];
        end
        for (int k = 2; k <= NS; k++) begin
            if ((k == 5) && !r_pin[4] && (r_mode[4] >= MODE_QUAD) &&
                (r_mode[4] <= MODE_QUINT)) begin
                r_res[k] <= n_pw_res;
            end else if ((k == 6) && !r_pin[5] && (r_mode[5] == MODE_CIRC)) begin
                r_res[k] <= n_circ_res;
            end else if ((k == NS) && !r_pin[NS-1] && (r_mode[NS-1] == MODE_SINE)) begin
                r_res[k] <= n_sin_res;
            end else begin
                r_res[k] <= r_res[k-1];
            end
        end
        for (int k = 2; k <= 3; k++) begin
            r_u[k] <= r_u[k-1];
        end
        for (int k = 2; k <= 5; k++) begin
            r_n[k]  <= r_n[k-1];
            r_sq[k] <= n_sq[k];
        end
        for (int k = 2; k <= 23; k++) begin
            r_a[k] <= r_a[k-1];
        end
        for (int k = 3; k <= 20; k++) begin
            r_a2[k] <= r_a2[k-1];
        end

        // stage 1
        r_mode[1] <= r_curve_mode;
        r_pin[1]  <= n_pin;
        r_res[1]  <= n_res1;
        r_u[1]    <= 16'(ONE - OUT_W'(n_x));
        r_pw[1]   <= 80'(32'(16'(ONE - OUT_W'(n_x))) * 32'(16'(ONE - OUT_W'(n_x))));
        r_n[1]    <= 32'(34'(n_x) * (34'd1 << (FRAC_BITS + 1)) - 34'(n_x) * 34'(n_x));
        r_sq[1]   <= '0;
        r_a[1]    <= 31'((48'(n_x) * 48'(HALF_PI_Q30)) >> FRAC_BITS);

        // power chain
        r_pw[2] <= ((r_mode[1] >= MODE_CUBIC) && (r_mode[1] <= MODE_QUINT)) ?
                   80'(48'(r_pw[1][31:0]) * 48'(r_u[1])) : r_pw[1];
        r_pw[3] <= ((r_mode[2] >= MODE_QUART) && (r_mode[2] <= MODE_QUINT)) ?
                   80'(64'(r_pw[2][47:0]) * 64'(r_u[2])) : r_pw[2];
        r_pw[4] <= (r_mode[3] == MODE_QUINT) ?
                   80'(r_pw[3][63:0]) * 80'(r_u[3]) : r_pw[3];

        // sine chain
        r_a2[2] <= 32'((64'(r_a[1]) * 64'(r_a[1])) >> 30);
        r_h[2]  <= Q30_ONE;
        for (int j = 0; j < 7; j++) begin
            r_sp[3+3*j] <= 32'((64'(r_a2[2+3*j]) * 64'(r_h[2+3*j])) >> 30);
            r_sp[4+3*j] <= r_sp[3+3*j];
            r_q[4+3*j]  <= 32'((64'(r_sp[3+3*j]) * 64'(SIN_RECIP[j])) >> 32);
            r_h[5+3*j]  <= n_h[j];
        end
        r_s <= 32'((64'(r_a[23]) * 64'(r_h[23])) >> 30);
    end

endmodule

// File: rtl/core/easing_curve_evaluator_checker.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator_checker
// port level checks of the easing curve evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "easing_curve_evaluator_defines.svh"

module easing_curve_evaluator_checker
    import ece_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic signed [IN_W-1:0]  i_progress,
    input logic                    i_cfg_we,
    input logic [2:0]              i_cfg_data,
    input logic                    o_valid,
    input logic [OUT_W-1:0]        o_position
);

    // results stay on the unit interval
    `ECE_ASSERT_RUN(a_range, i_clk, i_rst_n, o_valid |-> (o_position <= ONE))
    // every result comes from a transaction that was taken with start high
    `ECE_ASSERT_RUN(a_origin, i_clk, i_rst_n, o_valid |-> $past(start, NS))
    // negative progress pins to zero
    `ECE_ASSERT_RUN(a_neg, i_clk, i_rst_n,
        (o_valid && $past(i_progress[IN_W-1], NS)) |-> (o_position == '0))
    // reset flushes the pipeline
    `ECE_ASSERT_ALL(a_flush, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind easing_curve_evaluator easing_curve_evaluator_checker u_ece_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives progress values through every easing curve and checks each eased
// position against a bit-exact predictor, with random idle gaps and
// curve changes made only while no transaction is in flight
// ----------------------------------------------------------------------------
import ece_pkg::*;

class position_scoreboard;
    logic [OUT_W-1:0] pending_q[$];
    int               n_errors;

    function void note_input(logic [OUT_W-1:0] pos);
        pending_q.insert(pending_q.size(), pos);
    endfunction

    task report(string msg);
        $display("%s", msg);
        n_errors++;
    endtask

    task check_result(logic [OUT_W-1:0] got);
        logic [OUT_W-1:0] want;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected position %0d", got));
        end else begin
            want = pending_q.pop_front();
            if (got !== want) begin
                report($sformatf("position mismatch: got %0d want %0d", got, want));
            end
        end
    endtask
endclass

module testbench;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [IN_W-1:0] i_progress = '0;
    logic                   i_cfg_we = 1'b0;
    logic [2:0]             i_cfg_data = '0;
    logic                   o_valid;
    logic [OUT_W-1:0]       o_position;

    position_scoreboard sb = new();
    logic [2:0]         curve_sel = MODE_LINEAR;
    int                 idle_pct = 0;

    easing_curve_evaluator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_progress (i_progress),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_position (o_position)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_position);
        end
    end

    function automatic logic [63:0] power_pos(logic [63:0] x, int n);
        logic [255:0] acc;
        logic [63:0]  v;
        int           sh;
        acc = 256'd1;
        for (int i = 0; i < n; i++) acc = acc * (256'd65536 - 256'(x));
        sh = FRAC_BITS * (n - 1);
        acc = (acc + (256'd1 << (sh - 1))) >> sh;
        v = acc[63:0];
        return (v >= 64'd65536) ? 64'd0 : 64'd65536 - v;
    endfunction

    function automatic logic [63:0] circle_pos(logic [63:0] x);
        logic [63:0] n, r, c;
        n = x * (64'd131072 - x);
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if (c * c <= n) r = c;
        end
        if (n - r * r > r) r++;
        return r;
    endfunction

    function automatic logic [63:0] sine_pos(logic [63:0] x);
        logic [63:0] a, a2, h, t;
        a = (x * 64'd1686629713) >> FRAC_BITS;
        a2 = (a * a) >> 30;
        h = 64'd1 << 30;
        for (int k = 7; k >= 1; k--) begin
            t = ((a2 * h) >> 30) / 64'(2 * k * (2 * k + 1));
            h = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
        end
        a = (a * h) >> 30;
        return (a + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    function automatic logic [OUT_W-1:0] eased_position(logic [IN_W-1:0] p,
                                                        logic [2:0] m);
        logic [63:0] x, pos;
        x = 64'(p);
        if (p[IN_W-1] || p == '0) begin
            pos = 64'd0;
        end else if (x >= 64'd65536) begin
            pos = 64'd65536;
        end else begin
            case (m)
                MODE_QUAD:  pos = power_pos(x, 2);
                MODE_CUBIC: pos = power_pos(x, 3);
                MODE_QUART: pos = power_pos(x, 4);
                MODE_QUINT: pos = power_pos(x, 5);
                MODE_CIRC:  pos = circle_pos(x);
                MODE_SINE:  pos = sine_pos(x);
                default:    pos = x;
            endcase
            if (pos > 64'd65536) pos = 64'd65536;
        end
        return pos[OUT_W-1:0];
    endfunction

    task automatic send_progress(logic [IN_W-1:0] p);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_progress <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_input(eased_position(p, curve_sel));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic select_curve(logic [2:0] m);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        curve_sel = m;
        @(posedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] random_progress();
        case ($urandom_range(9))
            0:       return IN_W'($urandom);
            1:       return IN_W'($urandom_range(3));
            2:       return IN_W'(65536 - $urandom_range(3));
            default: return IN_W'($urandom_range(65535, 1));
        endcase
    endfunction

    initial begin
        #400000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        logic [IN_W-1:0] corner [12];
        corner = '{18'h00000, 18'h00001, 18'h08000, 18'h0FFFF, 18'h10000, 18'h10001,
                   18'h1FFFF, 18'h20000, 18'h3FFFF, 18'h2AAAA, 18'h15555, 18'h04000};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int m = 0; m < 8; m++) begin
            select_curve(m[2:0]);
            for (int i = 0; i < 3; i++) send_progress(corner[(m * 3 + i) % 12]);
        end
        select_curve(MODE_LINEAR);
        foreach (corner[i]) send_progress(corner[i]);
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 62;
                2: idle_pct = 37;
                3: idle_pct = 0;
                default: idle_pct = 0;
            endcase
            if (ph == 0) select_curve(MODE_LINEAR);
            else if (ph == 15) select_curve(MODE_SPARE);
            else select_curve(3'($urandom_range(7)));
            for (int i = 0; i < 90; i++) send_progress(random_progress());
        end
        drain_results();
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: easing_curve_evaluator.f
+incdir+rtl/core
rtl/core/ece_pkg.sv
rtl/core/easing_curve_evaluator.sv
rtl/core/easing_curve_evaluator_checker.sv
tb/sv/testbench.sv
